>>> rtl/fsc_pkg.sv
`timescale 1ns / 1ps
package fsc_pkg;

    localparam int ROUND_COUNT = 4;
    localparam int RND_W       = 2;
    localparam int STEP_COUNT  = 64;
    localparam int CFG_IDX_W   = 2;

    typedef logic [31:0] t_word;

    // one block as it moves down the pipeline
    typedef struct packed {
        logic        cmd;
        logic [63:0] half_a;
        logic [63:0] half_b;
    } t_blk;

    // compression state and the sliding 16-word message window
    typedef struct packed {
        t_word [7:0]  s;
        t_word [15:0] w;
    } t_hctx;

    localparam logic CMD_ENC = 1'b0;
    localparam logic CMD_DEC = 1'b1;

    localparam t_word [0:63] SHA_K = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    localparam t_word [0:7] SHA_IV = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    localparam t_word [0:3] ROUND_MASK = '{
        32'd134, 32'd19051, 32'd6604, 32'd20439
    };

    function automatic t_word rotr(input t_word x, input int n);
        rotr = (x >> n) | (x << (32 - n));
    endfunction

    function automatic t_word swap32(input t_word x);
        swap32 = {x[7:0], x[15:8], x[23:16], x[31:24]};
    endfunction

    function automatic t_word bsig0(input t_word x);
        bsig0 = rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
    endfunction

    function automatic t_word bsig1(input t_word x);
        bsig1 = rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
    endfunction

    function automatic t_word ssig0(input t_word x);
        ssig0 = rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
    endfunction

    function automatic t_word ssig1(input t_word x);
        ssig1 = rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
    endfunction

endpackage

>>> rtl/sha256_feistel_block_cipher_top.sv
`timescale 1ns / 1ps
// Four-round Feistel cipher on 16-byte blocks whose round function is the
// first 8 bytes of SHA-256 over (half || round key). Fully pipelined: one
// item may enter every cycle unless the output stalls; each item passes 4
// rounds of 64 hash-step registers plus one xor register each, the final
// round's xor register being the output register. The whole pipeline
// moves as one while the output is empty or being taken, so s_axis_tready
// follows m_axis_tready and bubbles are not squeezed out. Load the four
// key words through the cfg channel only while no item is in flight.
module sha256_feistel_block_cipher_top (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    // key write channel, always ready
    input  logic                         i_cfg_valid,
    output logic                         o_cfg_ready,
    input  logic [fsc_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [31:0]                  i_cfg_data,
    // input items
    input  logic                         s_axis_tvalid,
    output logic                         s_axis_tready,
    input  logic [127:0]                 s_axis_tdata,  // [63:0] half_a_in, [127:64] half_b_in
    input  logic                         s_axis_tuser,  // cmd: 0 encrypt, 1 decrypt
    // result items
    output logic                         m_axis_tvalid,
    input  logic                         m_axis_tready,
    output logic [127:0]                 m_axis_tdata   // [63:0] half_a_out, [127:64] half_b_out
);
    import fsc_pkg::*;

    t_word [3:0]          r_key;
    logic                 adv;
    logic [ROUND_COUNT:0] v;
    t_blk                 blk [ROUND_COUNT+1];

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key <= '0;
        end else if (i_cfg_valid) begin
            r_key[i_cfg_index] <= i_cfg_data;
        end
    end

    // global advance: output slot free or draining
    assign adv           = !v[ROUND_COUNT] || m_axis_tready;
    assign s_axis_tready = adv;

    assign v[0]          = s_axis_tvalid;
    assign blk[0].cmd    = s_axis_tuser;
    assign blk[0].half_a = s_axis_tdata[63:0];
    assign blk[0].half_b = s_axis_tdata[127:64];

    for (genvar g = 0; g < ROUND_COUNT; g++) begin : g_round
        fsc_round u_round (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_adv   (adv),
            .i_round (RND_W'(g)),
            .i_key   (r_key),
            .i_valid (v[g]),
            .i_blk   (blk[g]),
            .o_valid (v[g + 1]),
            .o_blk   (blk[g + 1])
        );
    end

    assign m_axis_tvalid = v[ROUND_COUNT];
    assign m_axis_tdata  = {blk[ROUND_COUNT].half_b, blk[ROUND_COUNT].half_a};

endmodule

>>> rtl/fsc_step.sv
`timescale 1ns / 1ps
// One SHA-256 compression round plus one message schedule word, registered.
module fsc_step (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_adv,
    input  fsc_pkg::t_word i_k,
    input  logic          i_valid,
    input  fsc_pkg::t_blk  i_blk,
    input  fsc_pkg::t_hctx i_ctx,
    output logic          o_valid,
    output fsc_pkg::t_blk  o_blk,
    output fsc_pkg::t_hctx o_ctx
);
    import fsc_pkg::*;

    t_word  t1, t2, ch, mj, e, a;
    t_hctx  n_ctx;
    logic   r_valid;
    t_blk   r_blk;
    t_hctx  r_ctx;

    always_comb begin
        a  = i_ctx.s[0];
        e  = i_ctx.s[4];
        ch = (e & i_ctx.s[5]) ^ (~e & i_ctx.s[6]);
        mj = (a & i_ctx.s[1]) ^ (a & i_ctx.s[2]) ^ (i_ctx.s[1] & i_ctx.s[2]);
        t1 = i_ctx.s[7] + bsig1(e) + ch + i_k + i_ctx.w[0];
        t2 = bsig0(a) + mj;
        n_ctx.s[0] = t1 + t2;
        n_ctx.s[1] = i_ctx.s[0];
        n_ctx.s[2] = i_ctx.s[1];
        n_ctx.s[3] = i_ctx.s[2];
        n_ctx.s[4] = i_ctx.s[3] + t1;
        n_ctx.s[5] = i_ctx.s[4];
        n_ctx.s[6] = i_ctx.s[5];
        n_ctx.s[7] = i_ctx.s[6];
        for (int j = 0; j < 15; j++) begin
            n_ctx.w[j] = i_ctx.w[j + 1];
        end
        n_ctx.w[15] = i_ctx.w[0] + ssig0(i_ctx.w[1]) + i_ctx.w[9] + ssig1(i_ctx.w[14]);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_adv) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_blk <= i_blk;
            r_ctx <= n_ctx;
        end
    end

    assign o_valid = r_valid;
    assign o_blk   = r_blk;
    assign o_ctx   = r_ctx;

endmodule

>>> rtl/fsc_round.sv
`timescale 1ns / 1ps
// One Feistel round: message load, 64 registered hash steps, final xor stage.
module fsc_round (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_adv,
    input  logic [fsc_pkg::RND_W-1:0] i_round,
    input  fsc_pkg::t_word [3:0]      i_key,
    input  logic                     i_valid,
    input  fsc_pkg::t_blk             i_blk,
    output logic                     o_valid,
    output fsc_pkg::t_blk             o_blk
);
    import fsc_pkg::*;

    logic                hash_b;
    logic [RND_W-1:0]    key_sel;
    logic [63:0]         x;
    t_word               mask;
    t_hctx               ld_ctx;

    logic [STEP_COUNT:0] v;
    t_blk                blk [STEP_COUNT+1];
    t_hctx               ctx [STEP_COUNT+1];

    logic [63:0]         hash;
    logic                hash_b_end;
    t_blk                n_blk;
    logic                r_valid;
    t_blk                r_blk;

    // even encrypt / odd decrypt rounds hash B into A, the others A into B
    always_comb begin
        hash_b  = ~i_round[0] ^ (i_blk.cmd == CMD_DEC);
        key_sel = (i_blk.cmd == CMD_DEC)
                  ? RND_W'(ROUND_COUNT - 1) - i_round : i_round;
        mask    = ROUND_MASK[key_sel];
        x       = hash_b ? i_blk.half_b : i_blk.half_a;
        for (int j = 0; j < 8; j++) begin
            ld_ctx.s[j] = SHA_IV[j];
        end
        ld_ctx.w[0] = x[63:32];
        ld_ctx.w[1] = x[31:0];
        for (int j = 0; j < 4; j++) begin
            ld_ctx.w[2 + j] = swap32(i_key[j] ^ mask);
        end
        ld_ctx.w[6] = 32'h8000_0000;
        for (int j = 7; j < 15; j++) begin
            ld_ctx.w[j] = '0;
        end
        ld_ctx.w[15] = 32'd192;
    end

    assign v[0]   = i_valid;
    assign blk[0] = i_blk;
    assign ctx[0] = ld_ctx;

    for (genvar g = 0; g < STEP_COUNT; g++) begin : g_step
        fsc_step u_step (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_adv   (i_adv),
            .i_k     (SHA_K[g]),
            .i_valid (v[g]),
            .i_blk   (blk[g]),
            .i_ctx   (ctx[g]),
            .o_valid (v[g + 1]),
            .o_blk   (blk[g + 1]),
            .o_ctx   (ctx[g + 1])
        );
    end

    always_comb begin
        hash       = {SHA_IV[0] + ctx[STEP_COUNT].s[0], SHA_IV[1] + ctx[STEP_COUNT].s[1]};
        hash_b_end = ~i_round[0] ^ (blk[STEP_COUNT].cmd == CMD_DEC);
        n_blk      = blk[STEP_COUNT];
        if (hash_b_end) begin
            n_blk.half_a = blk[STEP_COUNT].half_a ^ hash;
        end else begin
            n_blk.half_b = blk[STEP_COUNT].half_b ^ hash;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_adv) begin
            r_valid <= v[STEP_COUNT];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_blk <= n_blk;
        end
    end

    assign o_valid = r_valid;
    assign o_blk   = r_blk;

endmodule
